### hdl/psg_pkg.sv
// Shared types and constants for the tone/noise sample mixer.
`default_nettype none
package psg_pkg;
    localparam logic [1:0] MODE_TONE = 2'd0;
    localparam logic [1:0] MODE_VOL  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [1:0] CFG_DISABLED = 2'd0;
    localparam logic [1:0] CFG_NTSC     = 2'd1;
    localparam logic [1:0] CFG_MODMASK  = 2'd2;

    localparam logic [63:0] CLK_NTSC = 64'd3579545;
    localparam logic [63:0] CLK_PAL  = 64'd3546893;

    localparam int PHASE_W = 16;
    localparam int FRAC_W  = 16;
    // Dividend of the half-period test is phase << 17.
    localparam int NUM_W   = PHASE_W + 17;
    localparam int SUM_W   = 14;

    localparam logic [5:0] STEPS_A = 6'(NUM_W - 1);
    localparam logic [5:0] STEPS_B = 6'(PHASE_W);

    localparam logic [15:0] LFSR_SEED = 16'h8000;
    localparam logic [9:0]  NOISE_R0  = 10'h010;
    localparam logic [9:0]  NOISE_R1  = 10'h020;
    localparam logic [9:0]  NOISE_R2  = 10'h040;

    typedef struct packed {
        logic [1:0] ch;
        logic       wr_tone;
        logic       wr_amp;
        logic       sum_clr;
        logic       note_dec;
        logic       add_mod;
        logic       mul;
        logic       load_a;
        logic       load_b;
        logic       div_step;
        logic       add_tone;
        logic       phase_wr;
        logic       noise;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic dis;
        logic modu;
        logic note_zero;
        logic vol_zero;
        logic whole_zero;
        logic noise_on;
    } t_stat;
endpackage
`default_nettype wire

### hdl/psg_dp.sv
// Datapath: channel state, shared serial divider, noise LFSR and output mixer.
`default_nettype none
module psg_dp import psg_pkg::*; #(
    parameter int SAMPLE_RATE = 44100,
    parameter int NOTE_LENGTH = 4096
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [3:0]   i_cfg_data,
    input  wire logic [1:0]   i_channel,
    input  wire logic [9:0]   i_value,
    input  wire t_cmd         i_cmd,
    output t_stat             o_stat,
    output logic signed [15:0] o_sample
);
    localparam logic [63:0] RATE_NUM = 64'(SAMPLE_RATE) * 64'd64 * 64'd65536;
    localparam logic [63:0] F_NTSC = (RATE_NUM + CLK_NTSC / 64'd2) / CLK_NTSC;
    localparam logic [63:0] F_PAL  = (RATE_NUM + CLK_PAL / 64'd2) / CLK_PAL;
    localparam int FACTOR_W = $clog2(int'(F_PAL) + 1);
    localparam int SPAN_W   = 10 + FACTOR_W;
    localparam int WHOLE_W  = SPAN_W - FRAC_W;

    logic [9:0]  r_tone [4];
    logic [9:0]  r_amp [4];
    logic [12:0] r_note [3];
    logic [15:0] r_phase [3];
    logic [9:0]  r_ncnt;
    logic [15:0] r_lfsr;
    logic [3:0]  r_dis;
    logic        r_ntsc;
    logic [2:0]  r_modm;
    logic [SPAN_W-1:0] r_span;
    logic [NUM_W-1:0]  r_num;
    logic [SPAN_W:0]   r_rem;
    logic [SPAN_W-1:0] r_den;
    logic              r_q;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [15:0] r_sample;

    logic [FACTOR_W-1:0] factor;
    logic [WHOLE_W-1:0]  whole;
    logic [SPAN_W:0]     trial;
    logic                ge;
    logic [7:0]          level;
    logic [9:0]          ncnt_ld;
    logic [15:0]         lfsr_nx;
    logic                fb;
    logic signed [SUM_W+5:0] prod;
    logic [9:0]          vol;

    assign factor = r_ntsc ? FACTOR_W'(F_NTSC) : FACTOR_W'(F_PAL);
    assign whole  = r_span[SPAN_W-1:FRAC_W];
    assign trial  = {r_rem[SPAN_W-1:0], r_num[NUM_W-1]};
    assign ge     = trial >= {1'b0, r_den};
    assign vol    = r_amp[i_cmd.ch];
    assign level  = {r_tone[i_cmd.ch][5:0], 2'b00} - 8'd30;
    assign prod   = (SUM_W+6)'(r_sum) * (SUM_W+6)'(25);

    always_comb begin
        unique case (r_tone[3][1:0])
            2'd0: ncnt_ld = NOISE_R0;
            2'd1: ncnt_ld = NOISE_R1;
            2'd2: ncnt_ld = NOISE_R2;
            default: ncnt_ld = r_tone[2];
        endcase
        fb = r_tone[3][2] ? (r_lfsr[0] ^ r_lfsr[3]) : r_lfsr[0];
        lfsr_nx = (r_ncnt == 10'd0) ? {fb, r_lfsr[15:1]} : r_lfsr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_tone[k] <= '0;
                r_amp[k]  <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_note[k]  <= '0;
                r_phase[k] <= '0;
            end
            r_ncnt <= '0;
            r_lfsr <= LFSR_SEED;
            r_dis  <= '0;
            r_ntsc <= 1'b1;
            r_modm <= '0;
            r_sum  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DISABLED: r_dis  <= i_cfg_data;
                    CFG_NTSC:     r_ntsc <= i_cfg_data[0];
                    CFG_MODMASK:  r_modm <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.wr_tone) begin
                r_tone[i_channel] <= i_value;
                if (i_channel == 2'd3) begin
                    r_ncnt <= '0;
                    r_lfsr <= LFSR_SEED;
                end else begin
                    r_note[i_channel] <= 13'(NOTE_LENGTH);
                end
            end
            if (i_cmd.wr_amp) r_amp[i_channel] <= i_value;
            if (i_cmd.sum_clr) r_sum <= '0;
            if (i_cmd.note_dec) r_note[i_cmd.ch] <= r_note[i_cmd.ch] - 13'd1;
            if (i_cmd.add_mod) r_sum <= r_sum + SUM_W'(signed'(level));
            if (i_cmd.add_tone)
                r_sum <= r_q ? r_sum - SUM_W'(vol) : r_sum + SUM_W'(vol);
            if (i_cmd.phase_wr) r_phase[i_cmd.ch] <= r_rem[15:0];
            if (i_cmd.noise) begin
                // Reload and shift on an expired countdown, then count down.
                if (r_ncnt == 10'd0) begin
                    r_ncnt <= (ncnt_ld == 10'd0) ? 10'd0 : ncnt_ld - 10'd1;
                end else begin
                    r_ncnt <= r_ncnt - 10'd1;
                end
                r_lfsr <= lfsr_nx;
                r_sum <= lfsr_nx[0] ? r_sum + SUM_W'(r_amp[3])
                                    : r_sum - SUM_W'(r_amp[3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_span <= SPAN_W'(r_tone[i_cmd.ch] * factor);
        if (i_cmd.load_a) begin
            r_num <= {r_phase[i_cmd.ch], 17'd0};
            r_den <= r_span;
            r_rem <= '0;
        end
        if (i_cmd.load_b) begin
            r_num <= {17'(r_phase[i_cmd.ch]) + 17'd1, 16'd0};
            r_den <= SPAN_W'(whole);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? trial - {1'b0, r_den} : trial;
            r_q   <= ge;
        end
        if (i_cmd.out_load) begin
            if (prod > (SUM_W+6)'(32767))       r_sample <= 16'sh7FFF;
            else if (prod < -(SUM_W+6)'(32768)) r_sample <= 16'sh8000;
            else                                 r_sample <= prod[15:0];
        end
    end

    assign o_stat.dis        = r_dis[i_cmd.ch];
    assign o_stat.modu       = r_modm[i_cmd.ch];
    assign o_stat.note_zero  = r_note[i_cmd.ch] == 13'd0;
    assign o_stat.vol_zero   = vol == 10'd0;
    assign o_stat.whole_zero = whole == '0;
    assign o_stat.noise_on   = !r_dis[3] && (r_amp[3] != 10'd0);
    assign o_sample = r_sample;
endmodule
`default_nettype wire

### hdl/psg_ctrl.sv
// Controller: sequences writes and the per-channel steps of a sample tick.
`default_nettype none
module psg_ctrl import psg_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_mode,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_WHL  = 4'd3;
    localparam logic [3:0] S_DIVA = 4'd4;
    localparam logic [3:0] S_ADDA = 4'd5;
    localparam logic [3:0] S_DIVB = 4'd6;
    localparam logic [3:0] S_PWR  = 4'd7;
    localparam logic [3:0] S_NOIS = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_ch, n_ch;
    logic [5:0] r_cnt, n_cnt;
    logic       r_valid, n_valid;
    logic       accept;
    logic       last_ch;

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_valid;
    assign accept  = i_valid && o_ready;
    assign last_ch = r_ch == 2'd2;

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_cnt   = r_cnt;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        o_cmd.ch = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.wr_tone = i_mode == MODE_TONE;
                    o_cmd.wr_amp  = i_mode == MODE_VOL;
                    if (i_mode == MODE_TICK) begin
                        o_cmd.sum_clr = 1'b1;
                        n_ch = 2'd0;
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (i_stat.dis) begin
                    n_state = last_ch ? S_NOIS : S_CHK;
                    n_ch = r_ch + 2'd1;
                end else if (i_stat.modu) begin
                    o_cmd.add_mod = 1'b1;
                    n_state = last_ch ? S_NOIS : S_CHK;
                    n_ch = r_ch + 2'd1;
                end else if (i_stat.note_zero) begin
                    n_state = last_ch ? S_NOIS : S_CHK;
                    n_ch = r_ch + 2'd1;
                end else begin
                    o_cmd.note_dec = 1'b1;
                    if (i_stat.vol_zero) begin
                        n_state = last_ch ? S_NOIS : S_CHK;
                        n_ch = r_ch + 2'd1;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_WHL;
            end
            S_WHL: begin
                if (i_stat.whole_zero) begin
                    n_state = last_ch ? S_NOIS : S_CHK;
                    n_ch = r_ch + 2'd1;
                end else begin
                    o_cmd.load_a = 1'b1;
                    n_cnt = STEPS_A;
                    n_state = S_DIVA;
                end
            end
            S_DIVA: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) n_state = S_ADDA;
            end
            S_ADDA: begin
                // Quotient parity picks the half period.
                o_cmd.add_tone = 1'b1;
                o_cmd.load_b = 1'b1;
                n_cnt = STEPS_B;
                n_state = S_DIVB;
            end
            S_DIVB: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) n_state = S_PWR;
            end
            S_PWR: begin
                o_cmd.phase_wr = 1'b1;
                n_state = last_ch ? S_NOIS : S_CHK;
                n_ch = r_ch + 2'd1;
            end
            S_NOIS: begin
                o_cmd.noise = i_stat.noise_on;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free.
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

`ifndef SYNTHESIS
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_valid || i_ready))
        else $error("output overwritten while a beat waits");
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_TICK) |=> !o_ready)
        else $error("tick accepted without starting work");
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_NOIS && r_state != S_OUT) |-> r_ch != 2'd3)
        else $error("tone channel index out of range");
    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDA) |-> $past(r_state) == S_DIVA)
        else $error("divider result used without finishing");
`endif
endmodule
`default_nettype wire

### hdl/psg_tone_noise_sample_mixer_core.sv
// Top level of the tone/noise sample mixer.
`default_nettype none
// Three square-wave tone channels and one LFSR noise channel, mixed into one
// saturated signed 16-bit sample per tick beat; tone and volume beats update
// channel state and give no output beat. In a tick each sounding tone channel
// runs one shared bit-serial divider for 33 steps (half-period parity) and
// 17 steps (phase wrap). Disabled, modulated, note-expired or zero-volume
// channels pass through S_CHK only; a channel whose period rounds to zero
// samples goes through S_CHK, S_MUL and S_WHL. A stalled output beat holds
// the next tick in its last step. The user must make configuration writes
// only while the block is idle; the block itself does not enforce this.
module psg_tone_noise_sample_mixer_core import psg_pkg::*; #(
    parameter int SAMPLE_RATE = 44100,
    parameter int NOTE_LENGTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [1:0]  i_channel,
    input  wire logic [9:0]  i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [15:0] o_sample,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [3:0]  i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    psg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    psg_dp #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .NOTE_LENGTH (NOTE_LENGTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_channel  (i_channel),
        .i_value    (i_value),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_sample   (o_sample)
    );
endmodule
`default_nettype wire
